// ----- hw/rtl/slist_pkg.sv -----
package slist_pkg;

    localparam int WORD_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int ECOUNT_W = 5;

    // Operation codes carried by the func field.
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // Datapath operations on the cell array.
    typedef logic [1:0] slist_op_t;
    localparam slist_op_t OP_NOP    = 2'd0;
    localparam slist_op_t OP_INSERT = 2'd1;
    localparam slist_op_t OP_DELETE = 2'd2;
    localparam slist_op_t OP_ROTATE = 2'd3;

    typedef struct packed {
        slist_op_t             op;
        logic                  clr_idx;
        logic                  load_out;
        logic                  dump;
        logic                  last;
        logic [STATUS_W-1:0]   status;
    } slist_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic found;
        logic dump_last;
    } slist_stat_t;

endpackage

// ----- hw/rtl/slist_ctrl.sv -----
module slist_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [slist_pkg::FUNC_W-1:0]  func,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  slist_pkg::slist_stat_t        stat,
    output slist_pkg::slist_cmd_t         cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;
    logic accept;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.op     = slist_pkg::OP_NOP;
        cmd.status = slist_pkg::ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.last     = 1'b1;
                    cmd.load_out = 1'b1;
                    case (func)
                        slist_pkg::FUNC_INSERT:
                        begin
                            if (stat.full)
                                cmd.status = slist_pkg::ST_FULL;
                            else
                                cmd.op = slist_pkg::OP_INSERT;
                        end
                        slist_pkg::FUNC_DELETE:
                        begin
                            if (stat.found)
                                cmd.op = slist_pkg::OP_DELETE;
                            else
                                cmd.status = slist_pkg::ST_ABSENT;
                        end
                        slist_pkg::FUNC_DUMP:
                        begin
                            if (stat.empty)
                                cmd.status = slist_pkg::ST_EMPTY;
                            else
                            begin
                                cmd.load_out = 1'b0;
                                cmd.clr_idx  = 1'b1;
                                state_next   = S_DUMP;
                            end
                        end
                        default:
                        begin
                            cmd.status = slist_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    cmd.op       = slist_pkg::OP_ROTATE;
                    cmd.load_out = 1'b1;
                    cmd.dump     = 1'b1;
                    cmd.last     = stat.dump_last;
                    if (stat.dump_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/slist_dpath.sv -----
module slist_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [slist_pkg::WORD_W-1:0]    value,
    input  slist_pkg::slist_cmd_t                  cmd,
    output slist_pkg::slist_stat_t                 stat,
    output logic signed [slist_pkg::WORD_W-1:0]    entry_value,
    output logic                                   last,
    output logic [slist_pkg::STATUS_W-1:0]         status,
    output logic [slist_pkg::ECOUNT_W-1:0]         entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic signed [slist_pkg::WORD_W-1:0] cells_reg [DEPTH];
    logic signed [slist_pkg::WORD_W-1:0] cells_next [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;

    logic signed [slist_pkg::WORD_W-1:0] entry_reg;
    logic                                last_reg;
    logic [slist_pkg::STATUS_W-1:0]      status_reg;
    logic [slist_pkg::ECOUNT_W-1:0]      ecount_reg;

    logic [DEPTH-1:0] stays;    // valid cell that is not smaller than value
    logic [DEPTH-1:0] eq;       // valid cell equal to value
    logic [DEPTH-1:0] hit_pre;  // a match at or before this cell

    always_comb
    begin
        logic acc;
        acc = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            stays[i]   = (count_reg > CW'(i)) && !(cells_reg[i] < value);
            eq[i]      = (count_reg > CW'(i)) && (cells_reg[i] == value);
            acc        = acc | eq[i];
            hit_pre[i] = acc;
        end
    end

    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.found     = |eq;
    assign stat.dump_last = (CW'(idx_reg) == count_reg - CW'(1));

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        for (int i = 0; i < DEPTH; i++)
            cells_next[i] = cells_reg[i];
        case (cmd.op)
            slist_pkg::OP_INSERT:
            begin
                count_next = count_reg + CW'(1);
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!stays[i])
                    begin
                        if (i == 0 || stays[(i + DEPTH - 1) % DEPTH])
                            cells_next[i] = value;
                        else
                            cells_next[i] = cells_reg[(i + DEPTH - 1) % DEPTH];
                    end
                end
            end
            slist_pkg::OP_DELETE:
            begin
                count_next = count_reg - CW'(1);
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    if (hit_pre[i])
                        cells_next[i] = cells_reg[i + 1];
                end
            end
            slist_pkg::OP_ROTATE:
            begin
                // Turn the stored entries by one so cell 0 always holds the
                // next word of the dump; count steps restore the order.
                idx_next = idx_reg + IW'(1);
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (CW'(i + 1) < count_reg)
                        cells_next[i] = cells_reg[(i + 1) % DEPTH];
                    else if (CW'(i + 1) == count_reg)
                        cells_next[i] = cells_reg[0];
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        if (cmd.clr_idx)
            idx_next = '0;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            cells_reg[i] <= cells_next[i];
        if (cmd.load_out)
        begin
            entry_reg  <= cmd.dump ? cells_reg[0] : '0;
            last_reg   <= cmd.last;
            status_reg <= cmd.status;
            ecount_reg <= slist_pkg::ECOUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    assign entry_value = entry_reg;
    assign last        = last_reg;
    assign status      = status_reg;
    assign entry_count = ecount_reg;

endmodule

// ----- hw/rtl/sorted_list_insert_delete.sv -----
// Sorted list of up to DEPTH signed 32-bit values, kept largest first.
// The input channel (in_valid/in_ready) carries one word with func and value:
// insert places value ahead of the first smaller entry, delete removes the
// first equal entry, dump reads the whole list out from largest to smallest.
// The output channel (out_valid/out_ready) returns result words with
// entry_value, last, status and entry_count; last marks the final word of an
// item. For insert and delete, all cells compare against value in
// parallel and shift in place, and the single result is registered at the
// same edge that takes the item, so it is offered in the next cycle and one
// such item can be taken every cycle while out_ready is high. A dump of N
// entries gives N words: the first word enters the output register in the
// cycle after the dump is taken, then one word per cycle while out_ready is
// high, because the cell array turns by one cell per word; the next item is
// taken once the last dump word has entered the output register.
// When the receiver stalls, the output register holds its word and the block
// stops taking input until the word leaves. Reset empties the list and clears
// the output valid flag; no clearing pass is needed.
module sorted_list_insert_delete #(
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [slist_pkg::FUNC_W-1:0]           func,
    input  logic signed [slist_pkg::WORD_W-1:0]    value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [slist_pkg::WORD_W-1:0]    entry_value,
    output logic                                   last,
    output logic [slist_pkg::STATUS_W-1:0]         status,
    output logic [slist_pkg::ECOUNT_W-1:0]         entry_count
);

    // Commands from the controller and flags back from the cell array.
    slist_pkg::slist_cmd_t  cmd;
    slist_pkg::slist_stat_t stat;

    slist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    slist_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .cmd         (cmd),
        .stat        (stat),
        .entry_value (entry_value),
        .last        (last),
        .status      (status),
        .entry_count (entry_count)
    );

endmodule
